// File: rtl/ttl_token_table_assert.svh
`ifndef TTL_TOKEN_TABLE_ASSERT_SVH
`define TTL_TOKEN_TABLE_ASSERT_SVH

// Property that must hold in the same cycle as its trigger.
`define TTL_ASSERT_NOW(lbl, clk, rstn, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (trig) |-> (cond)) \
    else $error(msg);

// Property that must hold in the cycle after its trigger.
`define TTL_ASSERT_NEXT(lbl, clk, rstn, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (cond)) \
    else $error(msg);

`endif

// File: rtl/ttl_pkg.sv
package ttl_pkg;

  localparam int TTL_ENTRIES_DEF  = 64;
  localparam int TTL_KEY_BITS_DEF = 40;

  localparam int TIME_W = 32;
  localparam int EXP_W  = 33;
  localparam int LIVE_W = 7;

  localparam logic [TIME_W-1:0] TTL_RESET = 32'd3600;
  localparam logic [LIVE_W-1:0] LIVE_MAX  = 7'd127;

  localparam logic [1:0] CMD_GEN   = 2'd0;
  localparam logic [1:0] CMD_RENEW = 2'd1;
  localparam logic [1:0] CMD_COUNT = 2'd2;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

endpackage

// File: rtl/ttl_cell.sv
module ttl_cell import ttl_pkg::*; #(
  parameter int KEY_BITS = TTL_KEY_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                shift_i,
  input  logic                wr_i,
  input  logic                nb_used_i,
  input  logic [KEY_BITS-1:0] nb_key_i,
  input  logic [EXP_W-1:0]    nb_exp_i,
  input  logic [KEY_BITS-1:0] wr_key_i,
  input  logic [EXP_W-1:0]    wr_exp_i,
  output logic                used_o,
  output logic [KEY_BITS-1:0] key_o,
  output logic [EXP_W-1:0]    exp_o
);

  logic                used_q;
  logic [KEY_BITS-1:0] key_q;
  logic [EXP_W-1:0]    exp_q;

  // The used bit is the only state that reset has to clear.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
    end else if (shift_i) begin
      used_q <= nb_used_i;
    end else if (wr_i) begin
      used_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      key_q <= nb_key_i;
      exp_q <= nb_exp_i;
    end else if (wr_i) begin
      key_q <= wr_key_i;
      exp_q <= wr_exp_i;
    end
  end

  assign used_o = used_q;
  assign key_o  = key_q;
  assign exp_o  = exp_q;

endmodule

// File: rtl/ttl_token_table.sv
// Session token table with a time to live.
//
// Commands come in on start_i with cmd_i, token_key_i and now_i; a transaction
// is taken at a clock edge where start_i is high and busy_o is low. Generate
// stores the key with expiry now+ttl (reusing the key's entry, else the lowest
// empty or expired slot), renew extends a live token, count only reports.
// Every transaction yields one result: live_count_o and status_o, shown for a
// single cycle with done_o high. The receiver cannot stall; it must sample the
// result in that cycle.
// The ttl register is written through cfg_we_i / cfg_wdata_i; the user must
// do so only while idle, as the block itself does not enforce it. The
// entries sit in a ring of cells that rotates one place per cycle during the
// scan, so the single compare unit at the head sees every entry once. A write
// state then applies the update to the chosen cell, and the result is
// registered from it. A new command can be taken at the edge that takes the
// result, so the block takes no new command while one is still in progress.
// Reset empties the table (all used bits cleared), sets ttl to 3600 and
// leaves the block idle.
module ttl_token_table import ttl_pkg::*; #(
  parameter int TABLE_ENTRIES = TTL_ENTRIES_DEF,
  parameter int KEY_BITS      = TTL_KEY_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [1:0]          cmd_i,
  input  logic [KEY_BITS-1:0] token_key_i,
  input  logic [TIME_W-1:0]   now_i,
  input  logic                cfg_we_i,
  input  logic [TIME_W-1:0]   cfg_wdata_i,
  output logic                done_o,
  output logic [LIVE_W-1:0]   live_count_o,
  output logic [1:0]          status_o
);

  localparam int IdxW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CntW  = $clog2(TABLE_ENTRIES + 1);
  localparam int WideW = CntW + LIVE_W;

  // Controller states: idle, rotate the ring once, then apply the update.
  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_WRITE = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [TIME_W-1:0]   ttl_q;
  logic [1:0]          cmd_q;
  logic [KEY_BITS-1:0] key_q;
  logic [TIME_W-1:0]   now_q;
  logic [IdxW-1:0]     scan_q;

  // What the scan has learned about the table so far.
  logic                match_found_q, match_live_q, free_found_q;
  logic [IdxW-1:0]     match_idx_q, free_idx_q;
  logic [CntW-1:0]     cnt_q;

  logic                done_q;
  logic [LIVE_W-1:0]   live_count_q;
  status_e             status_q;

  // Ring of cells; cell 0 is the head that the compare unit looks at.
  logic                used_w [TABLE_ENTRIES];
  logic [KEY_BITS-1:0] key_w  [TABLE_ENTRIES];
  logic [EXP_W-1:0]    exp_w  [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] cell_wr;

  logic                shift;
  logic                accept;
  logic                head_live, head_match, last_scan;
  logic [EXP_W-1:0]    new_exp;
  logic                ttl_nz;

  logic                wr_en;
  logic [IdxW-1:0]     wr_idx;
  status_e             st_d;
  logic                dec, inc;
  logic [CntW-1:0]     cnt_after;
  logic [WideW-1:0]    cnt_wide;

  assign accept = start_i && (state_q == S_IDLE);
  assign shift  = (state_q == S_SCAN);

  for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
    localparam int Nb = (k + 1) % TABLE_ENTRIES;
    assign cell_wr[k] = wr_en && (wr_idx == IdxW'(k));
    ttl_cell #(
      .KEY_BITS(KEY_BITS)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (shift),
      .wr_i     (cell_wr[k]),
      .nb_used_i(used_w[Nb]),
      .nb_key_i (key_w[Nb]),
      .nb_exp_i (exp_w[Nb]),
      .wr_key_i (key_q),
      .wr_exp_i (new_exp),
      .used_o   (used_w[k]),
      .key_o    (key_w[k]),
      .exp_o    (exp_w[k])
    );
  end

  // Entry at the head during scan cycle c is entry c of the table.
  assign head_live  = used_w[0] && (exp_w[0] > EXP_W'(now_q));
  assign head_match = used_w[0] && (key_w[0] == key_q);
  assign last_scan  = (scan_q == IdxW'(TABLE_ENTRIES - 1));

  // now+ttl never wraps at 33 bits.
  assign new_exp = EXP_W'(now_q) + EXP_W'(ttl_q);
  assign ttl_nz  = (ttl_q != '0);

  // Update decision, taken once the scan has seen every entry. The live
  // count is corrected for the one entry that the update may touch.
  always_comb begin
    wr_en  = 1'b0;
    wr_idx = match_idx_q;
    st_d   = ST_DONE;
    dec    = 1'b0;
    inc    = 1'b0;
    case (cmd_q)
      CMD_GEN: begin
        if (match_found_q) begin
          wr_en = 1'b1;
          dec   = match_live_q;
          inc   = ttl_nz;
        end else if (free_found_q) begin
          wr_en  = 1'b1;
          wr_idx = free_idx_q;
          inc    = ttl_nz;
        end else begin
          st_d = ST_FULL;
        end
      end
      CMD_RENEW: begin
        if (match_found_q && match_live_q) begin
          wr_en = 1'b1;
          dec   = 1'b1;
          inc   = ttl_nz;
        end else begin
          st_d = ST_IGNORED;
        end
      end
      default: begin
      end
    endcase
    if (state_q != S_WRITE) begin
      wr_en = 1'b0;
    end
  end

  assign cnt_after = cnt_q - CntW'(dec) + CntW'(inc);
  assign cnt_wide  = WideW'(cnt_after);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (last_scan) begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      ttl_q         <= TTL_RESET;
      scan_q        <= '0;
      match_found_q <= 1'b0;
      match_live_q  <= 1'b0;
      free_found_q  <= 1'b0;
      cnt_q         <= '0;
      done_q        <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == S_WRITE);
      if (cfg_we_i) begin
        ttl_q <= cfg_wdata_i;
      end
      if (accept) begin
        scan_q        <= '0;
        match_found_q <= 1'b0;
        match_live_q  <= 1'b0;
        free_found_q  <= 1'b0;
        cnt_q         <= '0;
      end else if (shift) begin
        scan_q <= scan_q + IdxW'(1);
        cnt_q  <= cnt_q + CntW'(head_live);
        // Keep the lowest matching entry and the lowest reusable slot.
        if (head_match && !match_found_q) begin
          match_found_q <= 1'b1;
          match_live_q  <= head_live;
        end
        if (!head_live && !free_found_q) begin
          free_found_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
      key_q <= token_key_i;
      now_q <= now_i;
    end
    if (shift && head_match && !match_found_q) begin
      match_idx_q <= scan_q;
    end
    if (shift && !head_live && !free_found_q) begin
      free_idx_q <= scan_q;
    end
    if (state_q == S_WRITE) begin
      status_q     <= st_d;
      live_count_q <= (cnt_wide > WideW'(LIVE_MAX)) ? LIVE_MAX : cnt_wide[LIVE_W-1:0];
    end
  end

  assign busy_o       = (state_q != S_IDLE);
  assign done_o       = done_q;
  assign live_count_o = live_count_q;
  assign status_o     = status_q;

endmodule

// File: rtl/ttl_checker.sv
`include "ttl_token_table_assert.svh"

module ttl_checker import ttl_pkg::*; #(
  parameter int TABLE_ENTRIES = TTL_ENTRIES_DEF
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input logic              done_o,
  input logic [LIVE_W-1:0] live_count_o,
  input logic [1:0]        status_o
);

  localparam logic [LIVE_W-1:0] FullCount =
    (TABLE_ENTRIES > 127) ? LIVE_MAX : LIVE_W'(TABLE_ENTRIES);

  // A taken command keeps the block busy for the scan.
  `TTL_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start_i && !busy_o, busy_o, "not busy after start")

  // A result strobe is never repeated in consecutive cycles.
  `TTL_ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_o, !done_o, "result repeated")

  // The block is ready for the next command when it shows a result.
  `TTL_ASSERT_NOW(a_done_idle, clk_i, rst_ni, done_o, !busy_o, "busy while showing result")

  // A full table means every entry was live.
  `TTL_ASSERT_NOW(a_full_count, clk_i, rst_ni, done_o && (status_o == ST_FULL), live_count_o == FullCount, "full with a free slot")

endmodule

bind ttl_token_table ttl_checker #(
  .TABLE_ENTRIES(TABLE_ENTRIES)
) u_ttl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .done_o      (done_o),
  .live_count_o(live_count_o),
  .status_o    (status_o)
);

// File: tb/tb_ttl_token_table.sv
`timescale 1ns / 1ps

module tb_ttl_token_table;
  import ttl_pkg::*;

  localparam int KEY_W   = TTL_KEY_BITS_DEF;
  localparam int ENTRIES = TTL_ENTRIES_DEF;
  localparam int PHASES  = 8;

  // The one command code without an operation of its own.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Expected outcome of one transaction, in the order the block returns them.
  typedef struct packed {
    logic [LIVE_W-1:0] live_count;
    status_e           status;
  } token_result_t;

  // Shadow copy of the token table. Every accepted command is applied here
  // and the outcome is queued, then each strobed result is compared with
  // the oldest queued outcome.
  class token_scoreboard;
    logic              ent_used   [ENTRIES];
    logic [KEY_W-1:0]  ent_key    [ENTRIES];
    logic [EXP_W-1:0]  ent_expiry [ENTRIES];
    logic [TIME_W-1:0] ttl_value;
    token_result_t     expected_q [$];
    int unsigned       error_count;

    function new();
      ttl_value   = TTL_RESET;
      error_count = 0;
      foreach (ent_used[i]) begin
        ent_used[i]   = 1'b0;
        ent_key[i]    = '0;
        ent_expiry[i] = '0;
      end
    endfunction

    function void set_ttl(logic [TIME_W-1:0] value);
      ttl_value = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function bit is_live(int idx, logic [TIME_W-1:0] now);
      return ent_used[idx] && (ent_expiry[idx] > {1'b0, now});
    endfunction

    function int find_key(logic [KEY_W-1:0] key);
      int slot;
      slot = -1;
      for (int i = 0; i < ENTRIES && slot < 0; i++) begin
        if (ent_used[i] && ent_key[i] == key) slot = i;
      end
      return slot;
    endfunction

    function void note_request(logic [1:0] cmd, logic [KEY_W-1:0] key,
                               logic [TIME_W-1:0] now);
      token_result_t    res;
      logic [EXP_W-1:0] new_expiry;
      int               slot;
      int               live;
      // The expiry is one bit wider than time, so now+ttl never wraps.
      new_expiry = {1'b0, now} + {1'b0, ttl_value};
      res.status = ST_DONE;
      if (cmd == CMD_GEN) begin
        slot = find_key(key);
        // Without a matching entry, take the lowest slot that is not live.
        for (int i = 0; i < ENTRIES && slot < 0; i++) begin
          if (!is_live(i, now)) slot = i;
        end
        if (slot >= 0) begin
          ent_used[slot]   = 1'b1;
          ent_key[slot]    = key;
          ent_expiry[slot] = new_expiry;
        end else begin
          res.status = ST_FULL;
        end
      end else if (cmd == CMD_RENEW) begin
        slot = find_key(key);
        if (slot >= 0 && is_live(slot, now)) ent_expiry[slot] = new_expiry;
        else res.status = ST_IGNORED;
      end
      // Count and the unused code leave the table alone.
      live = 0;
      for (int i = 0; i < ENTRIES; i++) begin
        if (is_live(i, now)) live++;
      end
      res.live_count = (live > LIVE_MAX) ? LIVE_MAX : live[LIVE_W-1:0];
      expected_q = {expected_q, res};
    endfunction

    function void check_result(logic [LIVE_W-1:0] live, logic [1:0] status);
      token_result_t exp_res;
      if (expected_q.size() == 0) begin
        $display("%0t: result without a pending transaction: live_count %0d status %0d",
                 $time, live, status);
        error_count++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (live !== exp_res.live_count) begin
        $display("%0t: live_count mismatch: expected %0d, actual %0d",
                 $time, exp_res.live_count, live);
        error_count++;
      end
      if (status !== exp_res.status) begin
        $display("%0t: status mismatch: expected %0d, actual %0d",
                 $time, exp_res.status, status);
        error_count++;
      end
    endfunction
  endclass

  // All block inputs start at known values.
  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              start_i     = 1'b0;
  logic [1:0]        cmd_i       = CMD_COUNT;
  logic [KEY_W-1:0]  token_key_i = '0;
  logic [TIME_W-1:0] now_i       = '0;
  logic              cfg_we_i    = 1'b0;
  logic [TIME_W-1:0] cfg_wdata_i = '0;
  logic              busy_o;
  logic              done_o;
  logic [LIVE_W-1:0] live_count_o;
  logic [1:0]        status_o;

  token_scoreboard sb;

  ttl_token_table i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .cmd_i        (cmd_i),
    .token_key_i  (token_key_i),
    .now_i        (now_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .done_o       (done_o),
    .live_count_o (live_count_o),
    .status_o     (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The receiver cannot stall, so every strobed cycle is a transaction and
  // is checked at the edge that ends it.
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) sb.check_result(live_count_o, status_o);
  end

  // Idle gaps: mostly none or a few cycles, some spread over the whole
  // scan so that start rises at every point of the block's work, and a few
  // long ones.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return 0;
    if (r < 70) return $urandom_range(1, 4);
    if (r < 93) return $urandom_range(5, 70);
    return $urandom_range(71, 200);
  endfunction

  // Present one command and hold it until the block takes it. Start stays
  // high on return, so a back-to-back command needs no second assignment.
  task automatic send_item(input logic [1:0] cmd, input logic [KEY_W-1:0] key,
                           input logic [TIME_W-1:0] now);
    start_i     <= 1'b1;
    cmd_i       <= cmd;
    token_key_i <= key;
    now_i       <= now;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    sb.note_request(cmd, key, now);
  endtask

  // Drop start for a while; the payload wanders meanwhile, which the block
  // must ignore.
  task automatic idle_gap(input int unsigned cycles);
    if (cycles > 0) begin
      start_i     <= 1'b0;
      cmd_i       <= 2'($urandom);
      token_key_i <= KEY_W'({$urandom, $urandom});
      now_i       <= $urandom;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Every transaction has a result, so once the queue is empty the block
  // is idle; a few extra cycles cover the return to idle.
  task automatic wait_drained();
    start_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_ttl(input logic [TIME_W-1:0] value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_ttl(value);
  endtask

  initial begin
    logic [TIME_W-1:0] ph_ttl   [PHASES];
    int unsigned       ph_pool  [PHASES];
    int unsigned       ph_gen   [PHASES];
    logic [KEY_W-1:0]  key_pool [128];
    logic [KEY_W-1:0]  key_v;
    logic [1:0]        cmd_v;
    logic [TIME_W-1:0] cur_now;
    logic [TIME_W-1:0] ttl_v;
    logic [TIME_W-1:0] step_lim;
    logic [TIME_W:0]   sum;
    int unsigned       r;
    int unsigned       renew_lim;

    sb = new();
    // Settings per phase: the reset value, the shortest ttl, the longest
    // ttl with a pool large enough to fill the table, a zero ttl, and a
    // few in between. Phase five draws its ttl at random.
    ph_ttl  = '{TTL_RESET, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'd50, 32'd0, 32'd5, 32'd1000};
    ph_pool = '{70, 10, 120, 20, 100, 64, 8, 70};
    ph_gen  = '{50, 45, 85, 45, 50, 50, 45, 50};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, starting from the reset ttl of 3600.
    send_item(CMD_COUNT, '0, '0);                     // empty table
    send_item(CMD_RENEW, 40'd5, '0);                  // renew of an absent key
    send_item(CMD_GEN, '0, '0);
    send_item(CMD_GEN, '1, '0);
    send_item(CMD_GEN, '0, 32'd10);                   // same key reuses its entry
    send_item(CMD_RENEW, '0, 32'd100);
    send_item(CMD_UNUSED, '0, 32'd100);               // unused code acts as count
    send_item(CMD_RENEW, '1, 32'd3600);               // expiry equal to now is dead
    send_item(CMD_COUNT, '1, 32'd3600);
    send_item(CMD_GEN, '1, 32'd3601);                 // expired key reclaims its entry
    send_item(CMD_COUNT, '0, '0);                     // time running backwards
    send_item(CMD_GEN, 40'h12_3456_789A, 32'd4000);
    // A zero ttl expires a token the moment it is written.
    write_ttl('0);
    send_item(CMD_GEN, 40'd7, 32'd5000);
    send_item(CMD_RENEW, 40'd7, 32'd5000);
    send_item(CMD_COUNT, '0, 32'd4999);
    // Largest ttl at the latest time: the expiry needs the extra bit.
    write_ttl('1);
    send_item(CMD_GEN, 40'd9, '1);
    send_item(CMD_RENEW, 40'd9, '1);
    send_item(CMD_COUNT, '0, '1);

    // Random part. Keys come mostly from a small pool so that generates
    // hit existing entries, renews find their tokens and, with enough keys
    // and a long ttl, the table fills up.
    for (int ph = 0; ph < PHASES; ph++) begin
      ttl_v = (ph == 5) ? $urandom : ph_ttl[ph];
      write_ttl(ttl_v);
      for (int k = 0; k < 128; k++) key_pool[k] = KEY_W'({$urandom, $urandom});
      cur_now = $urandom;
      if (ttl_v < 64) step_lim = ttl_v + 2;
      else step_lim = ((ttl_v >> 5) > 32'h0010_0000) ? 32'h0010_0000 : (ttl_v >> 5);
      renew_lim = ph_gen[ph] + (100 - ph_gen[ph]) / 2;

      for (int n = 0; n < 128; n++) begin
        r = $urandom_range(0, 99);
        if (r < ph_gen[ph]) cmd_v = CMD_GEN;
        else if (r < renew_lim) cmd_v = CMD_RENEW;
        else if (r < 97) cmd_v = CMD_COUNT;
        else cmd_v = CMD_UNUSED;

        if ($urandom_range(0, 19) == 0) key_v = KEY_W'({$urandom, $urandom});
        else key_v = key_pool[$urandom_range(0, ph_pool[ph] - 1)];

        // Time mostly creeps forward; now and then it leaps past every
        // expiry or jumps to an arbitrary value, backwards included.
        r = $urandom_range(0, 99);
        if (r < 3) begin
          cur_now = $urandom;
        end else begin
          if (r < 6) sum = cur_now + ttl_v + $urandom_range(0, 100);
          else sum = cur_now + $urandom_range(0, step_lim);
          cur_now = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
        end

        send_item(cmd_v, key_v, cur_now);
        // The first stretch of every phase runs back to back.
        if (n >= 24) idle_gap(pick_gap());
      end
    end

    wait_drained();
    repeat (70) @(posedge clk_i);
    if (sb.error_count == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Far beyond the slowest correct run: every command behind a long gap
  // plus the full scan.
  initial begin
    #12_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
